/* rtl/pdf_pkg.sv */
// shared types, constants and helper functions for the packet deframer
package pdf_pkg;

  localparam int BYTE_W  = 8;
  localparam int LEN_W   = 10;
  localparam int KIND_W  = 2;
  localparam int PHASE_W = 2;

  // protocol characters
  localparam logic [BYTE_W-1:0] CH_NONE  = 8'h00;
  localparam logic [BYTE_W-1:0] CH_START = 8'h24;
  localparam logic [BYTE_W-1:0] CH_END   = 8'h23;
  localparam logic [BYTE_W-1:0] CH_ACK   = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_NAK   = 8'h2D;
  localparam logic [BYTE_W-1:0] CASE_BIT = 8'h20;
  localparam logic [BYTE_W-1:0] BAD_HEX  = 8'hFF;

  localparam logic [LEN_W-1:0] LIMIT_RESET = 10'd399;

  // phase codes
  localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
  localparam logic [PHASE_W-1:0] PH_DATA = 2'd1;
  localparam logic [PHASE_W-1:0] PH_HIGH = 2'd2;
  localparam logic [PHASE_W-1:0] PH_LOW  = 2'd3;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJECT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_RESTART = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [BYTE_W-1:0] payload_byte;
    logic [BYTE_W-1:0] ack_char;
    logic [LEN_W-1:0]  packet_length;
  } result_t;

  // hex digit value, all ones for a character that is not a hex digit
  function automatic logic [BYTE_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] u;
    u = c;
    if (c >= 8'h30 && c <= 8'h39) begin
      return c - 8'h30;
    end
    if (c >= 8'h61 && c <= 8'h7A) begin
      u = c - CASE_BIT;
    end
    if (u >= 8'h41 && u <= 8'h46) begin
      return u - 8'h41 + 8'd10;
    end
    return BAD_HEX;
  endfunction

endpackage

/* rtl/pdf_if.sv */
// handshake channel interfaces for received bytes and results
interface pdf_in_if import pdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface pdf_out_if import pdf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] result_kind;
  logic [BYTE_W-1:0] payload_byte;
  logic [BYTE_W-1:0] ack_char;
  logic [LEN_W-1:0]  packet_length;

  modport source (output valid, output result_kind, output payload_byte,
                  output ack_char, output packet_length, input ready);
  modport sink (input valid, input result_kind, input payload_byte,
                input ack_char, input packet_length, output ready);
endinterface

/* rtl/pdf_fsm.sv */
// framing state, running checksum and result decode for one byte per cycle while step is high
module pdf_fsm import pdf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [LEN_W-1:0]  cfg_wr_data,
  input  logic              step,
  input  logic [BYTE_W-1:0] rx_byte,
  output logic              res_valid,
  output result_t           res
);

  logic [LEN_W-1:0]   payload_limit;
  logic [PHASE_W-1:0] phase, phase_next;
  logic [BYTE_W-1:0]  running_sum, running_sum_next;
  logic [LEN_W-1:0]   byte_count, byte_count_next;
  logic [BYTE_W-1:0]  sent_sum_high, sent_sum_high_next;
  logic [PHASE_W-1:0] eff_phase;
  logic [BYTE_W-1:0]  digit;
  logic [BYTE_W-1:0]  sent_sum;

  // limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= LIMIT_RESET;
    end else if (cfg_wr_en) begin
      payload_limit <= cfg_wr_data;
    end
  end

  // next state and result for the byte in the input register
  always_comb begin
    phase_next         = phase;
    running_sum_next   = running_sum;
    byte_count_next    = byte_count;
    sent_sum_high_next = sent_sum_high;
    res_valid          = 1'b0;
    res                = '0;
    digit              = hex_value(rx_byte);
    sent_sum           = sent_sum_high + digit;
    eff_phase          = (phase == PH_DATA && byte_count >= payload_limit) ? PH_HIGH : phase;

    if (rx_byte != CH_NONE) begin
      unique case (eff_phase)
        PH_IDLE: begin
          if (rx_byte == CH_START) begin
            running_sum_next = '0;
            byte_count_next  = '0;
            phase_next       = PH_DATA;
          end
        end
        PH_DATA: begin
          if (rx_byte == CH_START) begin
            running_sum_next  = '0;
            byte_count_next   = '0;
            res_valid         = 1'b1;
            res.result_kind   = KIND_RESTART;
            res.packet_length = byte_count;
          end else if (rx_byte == CH_END) begin
            phase_next = PH_HIGH;
          end else begin
            running_sum_next = running_sum + rx_byte;
            byte_count_next  = byte_count + LEN_W'(1);
            res_valid        = 1'b1;
            res.result_kind  = KIND_PAYLOAD;
            res.payload_byte = rx_byte;
          end
        end
        PH_HIGH: begin
          sent_sum_high_next = {digit[3:0], 4'h0};
          phase_next         = PH_LOW;
        end
        PH_LOW: begin
          phase_next        = PH_IDLE;
          res_valid         = 1'b1;
          res.packet_length = byte_count;
          if (sent_sum == running_sum) begin
            res.result_kind = KIND_ACCEPT;
            res.ack_char    = CH_ACK;
          end else begin
            res.result_kind = KIND_REJECT;
            res.ack_char    = CH_NAK;
          end
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  // state registers advance when the byte moves on
  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      running_sum   <= '0;
      byte_count    <= '0;
      sent_sum_high <= '0;
    end else if (step) begin
      phase         <= phase_next;
      running_sum   <= running_sum_next;
      byte_count    <= byte_count_next;
      sent_sum_high <= sent_sum_high_next;
    end
  end

endmodule

/* rtl/pdf_out_reg.sv */
// result register in front of the output channel
module pdf_out_reg import pdf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      load_valid,
  input  result_t   load_res,
  output logic      can_accept,
  pdf_out_if.source out_ch
);

  logic    out_valid;
  result_t out_res;

  assign can_accept = !out_valid || out_ch.ready;

  // hold the result until the request is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (can_accept) begin
      out_valid <= load_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (can_accept && load_valid) begin
      out_res <= load_res;
    end
  end

  assign out_ch.valid         = out_valid;
  assign out_ch.result_kind   = out_res.result_kind;
  assign out_ch.payload_byte  = out_res.payload_byte;
  assign out_ch.ack_char      = out_res.ack_char;
  assign out_ch.packet_length = out_res.packet_length;

endmodule

/* rtl/packet_deframer_with_checksum_unit.sv */
// packet deframer: strips '$' ... '#' framing and checks the two-digit hex checksum
// path: input byte register, then result register; a result is registered as its byte leaves the byte register
// throughput: one byte per cycle; the byte register stalls only while the result
//   register holds an untaken request and the byte register is full
// reset (rst, synchronous): idle phase, sum and count cleared, limit back to 399,
//   no request pending on either register
module packet_deframer_with_checksum_unit import pdf_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  pdf_in_if.sink           in_ch,
  pdf_out_if.source        out_ch,
  input  logic             cfg_wr_en,
  input  logic [LEN_W-1:0] cfg_wr_data
);

  logic              s1_valid;
  logic [BYTE_W-1:0] s1_byte;
  logic              s1_fire;
  logic              can_accept;
  logic              res_valid;
  result_t           res;

  assign s1_fire     = s1_valid && can_accept;
  assign in_ch.ready = !s1_valid || can_accept;

  // input byte register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.valid && in_ch.ready) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_byte <= in_ch.rx_byte;
    end
  end

  pdf_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .step        (s1_fire),
    .rx_byte     (s1_byte),
    .res_valid   (res_valid),
    .res         (res)
  );

  pdf_out_reg u_out_reg (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s1_fire && res_valid),
    .load_res   (res),
    .can_accept (can_accept),
    .out_ch     (out_ch)
  );

`ifndef SYNTH
  // verdicts carry the right ack and no payload character
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.result_kind == KIND_ACCEPT
      |-> out_ch.ack_char == CH_ACK && out_ch.payload_byte == '0)
    else $error("accept verdict without '+' ack");

  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.result_kind == KIND_REJECT
      |-> out_ch.ack_char == CH_NAK && out_ch.payload_byte == '0)
    else $error("reject verdict without '-' ack");

  // payload results never carry an ack or a length
  assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.result_kind == KIND_PAYLOAD
      |-> out_ch.ack_char == '0 && out_ch.packet_length == '0)
    else $error("payload result with ack or length");

  // an empty character never produces a request
  assert property (@(posedge clk) disable iff (rst)
    s1_fire && s1_byte == CH_NONE |=> $stable(out_ch.valid) || !out_ch.valid)
    else $error("request from an empty character");
`endif

endmodule

/* test/tb.sv */
// testbench for the packet deframer: directed table, random framed traffic, scoreboard check
`timescale 1ns / 1ps

module tb;
  import pdf_pkg::*;

  typedef enum logic {OP_BYTE, OP_LIMIT} row_op_t;

  typedef struct packed {
    row_op_t    op;
    logic       typed;
    logic [9:0] val;
    result_t    want;
  } stim_row_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [LEN_W-1:0] cfg_wr_data;

  pdf_in_if  in_ch();
  pdf_out_if out_ch();

  packet_deframer_with_checksum_unit i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  // deframer state as the predictor sees it
  logic [PHASE_W-1:0] fr_phase = PH_IDLE;
  logic [BYTE_W-1:0]  fr_sum   = '0;
  logic [LEN_W-1:0]   fr_count = '0;
  logic [BYTE_W-1:0]  fr_high  = '0;
  logic [LEN_W-1:0]   fr_limit = LIMIT_RESET;

  result_t   frame_results[$];
  stim_row_t dir_rows[$];
  int        mismatches = 0;
  int        items_sent = 0;
  bit        in_calm    = 1'b0;
  bit        out_calm   = 1'b0;

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // hex digit value, all ones when the character is not a digit
  function automatic logic [BYTE_W-1:0] nibble_of(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] up;
    up = (c >= "a" && c <= "z") ? c - CASE_BIT : c;
    if (c >= "0" && c <= "9") return c - "0";
    if (up >= "A" && up <= "F") return up - "A" + 8'd10;
    return BAD_HEX;
  endfunction

  // hex character for a nibble, letters in random case
  function automatic logic [BYTE_W-1:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + n;
    if ($urandom_range(0, 1) == 0) return "a" + n - 8'd10;
    return "A" + n - 8'd10;
  endfunction

  // next deframer state and the result this character causes, if any
  function automatic bit deframe_char(input logic [BYTE_W-1:0] c, output result_t r);
    logic [BYTE_W-1:0] sent;
    r = '0;
    if (c == CH_NONE) return 1'b0;
    if (fr_phase == PH_DATA && fr_count >= fr_limit) fr_phase = PH_HIGH;
    case (fr_phase)
      PH_IDLE: begin
        if (c == CH_START) begin
          fr_sum   = '0;
          fr_count = '0;
          fr_phase = PH_DATA;
        end
        return 1'b0;
      end
      PH_DATA: begin
        if (c == CH_START) begin
          r.result_kind   = KIND_RESTART;
          r.packet_length = fr_count;
          fr_sum   = '0;
          fr_count = '0;
          return 1'b1;
        end
        if (c == CH_END) begin
          fr_phase = PH_HIGH;
          return 1'b0;
        end
        fr_sum   = fr_sum + c;
        fr_count = fr_count + 1'b1;
        r.result_kind  = KIND_PAYLOAD;
        r.payload_byte = c;
        return 1'b1;
      end
      PH_HIGH: begin
        fr_high  = nibble_of(c) << 4;
        fr_phase = PH_LOW;
        return 1'b0;
      end
      default: begin
        sent = fr_high + nibble_of(c);
        fr_phase = PH_IDLE;
        r.packet_length = fr_count;
        if (sent == fr_sum) begin
          r.result_kind = KIND_ACCEPT;
          r.ack_char    = CH_ACK;
        end else begin
          r.result_kind = KIND_REJECT;
          r.ack_char    = CH_NAK;
        end
        return 1'b1;
      end
    endcase
  endfunction

  // gap before the next request, with calm stretches of back-to-back traffic
  function automatic int in_gap();
    if ($urandom_range(0, 63) == 0) in_calm = !in_calm;
    return in_calm ? 0 : $urandom_range(0, 18);
  endfunction

  function automatic int out_gap();
    if ($urandom_range(0, 63) == 0) out_calm = !out_calm;
    return out_calm ? 0 : $urandom_range(0, 18);
  endfunction

  // table rows
  function automatic stim_row_t rx_row(input logic [BYTE_W-1:0] c);
    stim_row_t row;
    row = '0;
    row.op  = OP_BYTE;
    row.val = {2'b00, c};
    return row;
  endfunction

  function automatic stim_row_t rx_row_exp(input logic [BYTE_W-1:0] c,
                                           input logic [KIND_W-1:0] kind,
                                           input logic [BYTE_W-1:0] pbyte,
                                           input logic [BYTE_W-1:0] ack,
                                           input logic [LEN_W-1:0] len);
    stim_row_t row;
    row = rx_row(c);
    row.typed              = 1'b1;
    row.want.result_kind   = kind;
    row.want.payload_byte  = pbyte;
    row.want.ack_char      = ack;
    row.want.packet_length = len;
    return row;
  endfunction

  function automatic stim_row_t cfg_row(input logic [LEN_W-1:0] v);
    stim_row_t row;
    row = '0;
    row.op  = OP_LIMIT;
    row.val = v;
    return row;
  endfunction

  // drive one character request, predict on acceptance
  task automatic send_byte(input logic [BYTE_W-1:0] c, input bit typed = 1'b0,
                           input result_t want = '0);
    int      gap;
    bit      hit;
    result_t pred;
    gap = in_gap();
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid   = 1'b1;
    in_ch.rx_byte = c;
    do @(posedge clk); while (!in_ch.ready);
    hit = deframe_char(c, pred);
    if (typed) frame_results.push_back(want);
    else if (hit) frame_results.push_back(pred);
    items_sent++;
    @(negedge clk);
  endtask

  // occasional empty character
  task automatic maybe_none();
    if ($urandom_range(0, 24) == 0) send_byte(CH_NONE);
  endtask

  // let everything in flight drain, then write the limit
  task automatic write_limit(input logic [LEN_W-1:0] v);
    in_ch.valid = 1'b0;
    while (frame_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = v;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    fr_limit  = v;
  endtask

  // one framed packet with random payload; len_req below zero picks a length
  task automatic send_packet(input int len_req);
    int          len;
    int          cnt;
    int          cap;
    int unsigned roll;
    logic [7:0]  sum;
    logic [7:0]  c;
    roll = $urandom_range(0, 99);
    cap  = (fr_limit < 10'd12) ? int'(fr_limit) : 12;
    if (len_req >= 0) len = (len_req < int'(fr_limit)) ? len_req : int'(fr_limit);
    else if (roll % 5 == 0) len = cap;
    else len = $urandom_range(0, cap);
    sum = '0;
    cnt = 0;
    send_byte(CH_START);
    for (int i = 0; i < len; i++) begin
      // restart in the middle of a few packets
      if (roll < 8 && i == len / 2) begin
        send_byte(CH_START);
        sum = '0;
        cnt = 0;
      end
      maybe_none();
      do c = 8'($urandom_range(1, 255)); while (c == CH_START || c == CH_END);
      send_byte(c);
      sum = sum + c;
      cnt++;
    end
    // end mark unless the limit already closed the payload; a stray one now and then
    if (cnt < int'(fr_limit) || roll >= 95) send_byte(CH_END);
    if (roll >= 25) begin
      send_byte(hex_char(sum[7:4]));
      maybe_none();
      send_byte(hex_char(sum[3:0]));
    end else begin
      repeat (2) begin
        if ($urandom_range(0, 1) == 0) send_byte(hex_char(4'($urandom_range(0, 15))));
        else send_byte(8'($urandom_range(1, 255)));
      end
    end
  endtask

  // result sink: random stall before each request is taken
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = out_gap();
      if (gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  // compare each taken result with the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (frame_results.size() == 0) begin
        $error("result_kind: expected no result, got %0d", out_ch.result_kind);
        mismatches++;
      end else begin
        want = frame_results.pop_front();
        check_field("result_kind", want.result_kind, out_ch.result_kind);
        check_field("payload_byte", want.payload_byte, out_ch.payload_byte);
        check_field("ack_char", want.ack_char, out_ch.ack_char);
        check_field("packet_length", want.packet_length, out_ch.packet_length);
      end
    end
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("packet_deframer_with_checksum_unit test failed");
    $finish;
  end

  // stimulus
  initial begin
    int start;
    int waited;
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.rx_byte = '0;
    cfg_wr_en     = 1'b0;
    cfg_wr_data   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: ignored characters, extremes, restart, both digit cases, bad digits,
    // framing characters as digits, limit lowered mid-packet, limit of zero
    dir_rows.push_back(rx_row(CH_NONE));
    dir_rows.push_back(rx_row("A"));
    dir_rows.push_back(rx_row(CH_START));
    dir_rows.push_back(rx_row(CH_NONE));
    dir_rows.push_back(rx_row_exp(8'hFF, KIND_PAYLOAD, 8'hFF, 8'h00, 10'd0));
    dir_rows.push_back(rx_row_exp(8'h01, KIND_PAYLOAD, 8'h01, 8'h00, 10'd0));
    dir_rows.push_back(rx_row_exp(CH_START, KIND_RESTART, 8'h00, 8'h00, 10'd2));
    dir_rows.push_back(rx_row_exp(8'hAF, KIND_PAYLOAD, 8'hAF, 8'h00, 10'd0));
    dir_rows.push_back(rx_row(CH_END));
    dir_rows.push_back(rx_row("a"));
    dir_rows.push_back(rx_row_exp("F", KIND_ACCEPT, 8'h00, CH_ACK, 10'd1));
    dir_rows.push_back(rx_row(CH_START));
    dir_rows.push_back(rx_row(CH_END));
    dir_rows.push_back(rx_row("g"));
    dir_rows.push_back(rx_row_exp(CH_END, KIND_REJECT, 8'h00, CH_NAK, 10'd0));
    dir_rows.push_back(rx_row(CH_START));
    dir_rows.push_back(rx_row_exp(8'hEF, KIND_PAYLOAD, 8'hEF, 8'h00, 10'd0));
    dir_rows.push_back(rx_row(CH_END));
    dir_rows.push_back(rx_row("x"));
    dir_rows.push_back(rx_row_exp(CH_START, KIND_ACCEPT, 8'h00, CH_ACK, 10'd1));
    dir_rows.push_back(rx_row(CH_START));
    dir_rows.push_back(rx_row("a"));
    dir_rows.push_back(rx_row("b"));
    dir_rows.push_back(cfg_row(10'd1));
    dir_rows.push_back(rx_row("c"));
    dir_rows.push_back(rx_row_exp("3", KIND_ACCEPT, 8'h00, CH_ACK, 10'd2));
    dir_rows.push_back(cfg_row(10'd0));
    dir_rows.push_back(rx_row(CH_START));
    dir_rows.push_back(rx_row("0"));
    dir_rows.push_back(rx_row_exp("0", KIND_ACCEPT, 8'h00, CH_ACK, 10'd0));

    foreach (dir_rows[i]) begin
      if (dir_rows[i].op == OP_LIMIT) write_limit(dir_rows[i].val);
      else send_byte(dir_rows[i].val[7:0], dir_rows[i].typed, dir_rows[i].want);
    end

    // random: mostly framed packets, some noise, over several limits
    for (int p = 0; p < 7; p++) begin
      case (p)
        0: write_limit(10'd1023);
        1: write_limit(10'd1);
        2: write_limit(10'd2);
        3: write_limit(10'($urandom_range(3, 12)));
        4: write_limit(LIMIT_RESET);
        5: write_limit(10'($urandom_range(1, 1023)));
        default: write_limit(10'($urandom_range(1, 8)));
      endcase
      start = items_sent;
      while (items_sent - start < 135) begin
        if ($urandom_range(0, 4) == 0) begin
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        end else begin
          send_packet(-1);
        end
      end
    end

    // drain
    in_ch.valid = 1'b0;
    waited = 0;
    while (frame_results.size() != 0 && waited < 20000) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(negedge clk);
    if (frame_results.size() != 0) begin
      $error("result_kind: expected %0d more results, got none",
             frame_results.size());
      mismatches++;
    end
    if (mismatches == 0) begin
      $display("packet_deframer_with_checksum_unit test passed");
    end else begin
      $display("packet_deframer_with_checksum_unit test failed");
    end
    $finish;
  end

endmodule
